/* sv/bba_pkg.sv */
package bba_pkg;

    // fixed field widths
    localparam int WORD_BITS   = 64;
    localparam int BYTE_BITS   = 8;
    localparam int BIT_W       = 6;
    localparam int ID_W        = 32;
    localparam int MAPCNT_W    = 4;
    localparam int ACT_W       = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    typedef logic [1:0] t_status;

    // result status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_RANGE = 2'd2;

    // request kinds
    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_BLOCKS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_OFFSET = 1'd1;

    typedef struct packed {
        logic            func;
        logic [ID_W-1:0] free_id;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0] alloc_id;
        t_status         status;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic    clr_step;
        logic    load;
        logic    read;
        logic    modify;
        logic    emit;
        t_status emit_status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic alloc_hit;
        logic in_range;
        logic in_mem;
    } t_stat;

endpackage

/* sv/bitmap_block_allocator_unit.sv */
// A full map, an out-of-range free or a free past the stored map is answered in the lookup
// state; a map word read-modify-write passes lookup and modify. o_done is registered.
// A new request is taken only once o_busy is low again, so requests do not overlap.
// Reset: synchronous; afterwards a clearing pass zeroes all MAX_MAP_BLOCKS*BLOCK_BYTES/8
// map words (512 by default) with o_busy high. Config writes are taken at any time.
// Results cannot be stalled by the receiver.
module bitmap_block_allocator_unit #(
    parameter int BLOCK_BYTES    = 512,
    parameter int MAX_MAP_BLOCKS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  bba_pkg::t_req                  i_req,
    output logic                          o_done,
    output bba_pkg::t_result               o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bba_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    bba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_busy  (o_busy),
        .o_cmd   (cmd)
    );

    bba_dpath #(
        .BLOCK_BYTES    (BLOCK_BYTES),
        .MAX_MAP_BLOCKS (MAX_MAP_BLOCKS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_done      (o_done),
        .o_result    (o_result)
    );

endmodule

/* sv/bba_ctrl.sv */
module bba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  bba_pkg::t_stat i_stat,
    output logic          o_busy,
    output bba_pkg::t_cmd  o_cmd
);
    import bba_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;
    localparam logic [1:0] S_MOD   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                if (!i_stat.is_free) begin
                    if (i_stat.alloc_hit) begin
                        o_cmd.read = 1'b1;
                        n_state    = S_MOD;
                    end else begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = ST_FULL;
                        n_state           = S_IDLE;
                    end
                end else if (!i_stat.in_range) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = ST_RANGE;
                    n_state           = S_IDLE;
                end else if (!i_stat.in_mem) begin
                    // in range but past the stored map: nothing to clear
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = ST_OK;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.read = 1'b1;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.modify = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* sv/bba_dpath.sv */
module bba_dpath #(
    parameter int BLOCK_BYTES    = 512,
    parameter int MAX_MAP_BLOCKS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bba_pkg::t_req                  i_req,
    input  bba_pkg::t_cmd                  i_cmd,
    output bba_pkg::t_stat                 o_stat,
    input  logic                          i_cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                          o_done,
    output bba_pkg::t_result               o_result
);
    import bba_pkg::*;

    localparam int WPM   = BLOCK_BYTES / BYTE_BITS;
    localparam int SLOTS = BLOCK_BYTES * BYTE_BITS;
    localparam int TOTAL = MAX_MAP_BLOCKS * WPM;
    localparam int WA    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int GW    = (MAX_MAP_BLOCKS > 1) ? $clog2(MAX_MAP_BLOCKS) : 1;
    localparam int IW    = (WPM > 1) ? $clog2(WPM) : 1;

    // lowest set bit among the groups
    function automatic logic [GW-1:0] first_set_grp(input logic [MAX_MAP_BLOCKS-1:0] v);
        logic [GW-1:0] r;
        r = '0;
        for (int i = MAX_MAP_BLOCKS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = GW'(i);
            end
        end
        return r;
    endfunction

    // lowest clear bit of a summary slice
    function automatic logic [IW-1:0] first_zero_wrd(input logic [WPM-1:0] v);
        logic [IW-1:0] r;
        r = '0;
        for (int i = WPM - 1; i >= 0; i--) begin
            if (!v[i]) begin
                r = IW'(i);
            end
        end
        return r;
    endfunction

    // lowest clear bit of a map word
    function automatic logic [BIT_W-1:0] first_zero_bit(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!v[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

    // configuration
    logic [MAPCNT_W-1:0] r_map_blocks;
    logic [ID_W-1:0]     r_data_offset;

    // request capture
    logic            r_func;
    logic [ID_W-1:0] r_bid;

    // word in flight
    logic [WA-1:0]        r_addr;
    logic [BIT_W-1:0]     r_bit;
    logic [WORD_BITS-1:0] r_rdata;

    // map storage, clear pass and full-word summary
    logic [WORD_BITS-1:0] r_mem [TOTAL];
    logic [WA-1:0]        r_clr_addr;
    logic [TOTAL-1:0]     r_summary;

    logic                  r_done;
    t_result               r_result;

    logic [ACT_W-1:0]          active;
    logic [MAX_MAP_BLOCKS-1:0] grp_open;
    logic [GW-1:0]             grp_sel;
    logic [WA-1:0]             grp_base;
    logic [IW-1:0]             wrd_sel;
    logic [WA-1:0]             alloc_addr;
    logic [ID_W-1:0]           rel;
    logic [ID_W-1:0]           limit;
    logic [WA-1:0]             free_addr;
    logic [WA-1:0]             look_addr;
    logic [BIT_W-1:0]          mod_bit;
    logic [WORD_BITS-1:0]      bit_mask;
    logic [WORD_BITS-1:0]      new_word;
    logic                      mem_we;
    logic [WA-1:0]             mem_waddr;
    logic [WORD_BITS-1:0]      mem_wdata;
    t_result                   mod_result;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_blocks  <= MAPCNT_W'(8);
            r_data_offset <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAP_BLOCKS:  r_map_blocks  <= i_cfg_data[MAPCNT_W-1:0];
                CFG_DATA_OFFSET: r_data_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // map blocks in use, capped at the built size
    always_comb begin
        if (ACT_W'(r_map_blocks) > ACT_W'(MAX_MAP_BLOCKS)) begin
            active = ACT_W'(MAX_MAP_BLOCKS);
        end else begin
            active = ACT_W'(r_map_blocks);
        end
    end

    // a group is open when in use and holding a word with a free bit
    for (genvar g = 0; g < MAX_MAP_BLOCKS; g++) begin : g_grp
        assign grp_open[g] = (ACT_W'(g) < active) && !(&r_summary[g*WPM +: WPM]);
    end

    // first open group, then its first non-full word
    assign grp_sel    = first_set_grp(grp_open);
    assign grp_base   = WA'(grp_sel) * WA'(WPM);
    assign wrd_sel    = first_zero_wrd(r_summary[grp_base +: WPM]);
    assign alloc_addr = grp_base + WA'(wrd_sel);

    // free: relative slot, range check against the in-use map
    assign rel       = r_bid - r_data_offset;
    assign limit     = ID_W'(active) * ID_W'(SLOTS);
    assign free_addr = rel[BIT_W +: WA];
    assign look_addr = r_func ? free_addr : alloc_addr;

    assign o_stat.clr_last  = (r_clr_addr == WA'(TOTAL - 1));
    assign o_stat.is_free   = (r_func == FN_FREE);
    assign o_stat.alloc_hit = |grp_open;
    assign o_stat.in_range  = (rel < limit);
    assign o_stat.in_mem    = (rel[ID_W-1:BIT_W] < (ID_W - BIT_W)'(TOTAL));

    // request capture and word address
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_req.func;
            r_bid  <= i_req.free_id;
        end
        if (i_cmd.read) begin
            r_addr <= look_addr;
            r_bit  <= rel[BIT_W-1:0];
        end
    end

    // set or clear the chosen bit
    assign mod_bit  = r_func ? r_bit : first_zero_bit(r_rdata);
    assign bit_mask = WORD_BITS'(1) << mod_bit;
    assign new_word = r_func ? (r_rdata & ~bit_mask) : (r_rdata | bit_mask);

    // clear pass shares the single write port
    assign mem_we    = i_cmd.clr_step || i_cmd.modify;
    assign mem_waddr = i_cmd.clr_step ? r_clr_addr : r_addr;
    assign mem_wdata = i_cmd.clr_step ? '0 : new_word;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.read) begin
            r_rdata <= r_mem[look_addr];
        end
    end

    // clear pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + WA'(1);
        end
    end

    // full-word summary follows every read-modify-write of a word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_summary <= '0;
        end else if (i_cmd.modify) begin
            r_summary[r_addr] <= &new_word;
        end
    end

    always_comb begin
        mod_result.status = ST_OK;
        if (r_func) begin
            mod_result.alloc_id = '0;
        end else begin
            mod_result.alloc_id = ID_W'({r_addr, mod_bit}) + r_data_offset;
        end
    end

    // result word, shown for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit || i_cmd.modify;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_result.alloc_id <= '0;
            r_result.status   <= i_cmd.emit_status;
        end else if (i_cmd.modify) begin
            r_result <= mod_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

/* sv/bba_checker.sv */
module bba_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_start,
    input logic                          o_busy,
    input logic                          o_done,
    input bba_pkg::t_result               o_result
);
    import bba_pkg::*;

    // a taken request keeps the unit busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request taken but unit not busy");

    // a result word ends the request: unit is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!o_busy && $past(o_busy)))
        else $error("result word outside a request");

    // no two result words in a row
    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("back to back result words");

    // failures carry a zero block number
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == ST_FULL || o_result.status == ST_RANGE))
            |-> (o_result.alloc_id == '0))
        else $error("nonzero block number on failed request");

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_result (o_result)
);

/* sim/bitmap_block_allocator_unit_tb.sv */
`timescale 1ns / 100ps

module bitmap_block_allocator_unit_tb;
    import bba_pkg::*;

    localparam int BLOCK_BYTES    = 512;
    localparam int MAX_MAP_BLOCKS = 8;
    localparam int WORDS_PER_MAP  = BLOCK_BYTES / BYTE_BITS;
    localparam int SLOTS_PER_MAP  = BLOCK_BYTES * BYTE_BITS;
    localparam int TOTAL_WORDS    = MAX_MAP_BLOCKS * WORDS_PER_MAP;
    localparam int IDLE_LIMIT     = 4000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    t_req                  i_req;
    logic                  o_done;
    t_result               o_result;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // shadow of the usage bitmap and the registers
    logic [WORD_BITS-1:0] slot_map [TOTAL_WORDS];
    logic [MAPCNT_W-1:0]  cur_map_blocks;
    logic [ID_W-1:0]      cur_offset;

    t_result              pending_results [$];
    int unsigned          live_slots [$];
    int                   err_cnt;
    int                   idle_cycles;
    bit                   burst_mode;

    bitmap_block_allocator_unit #(
        .BLOCK_BYTES    (BLOCK_BYTES),
        .MAX_MAP_BLOCKS (MAX_MAP_BLOCKS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int active_maps();
        return (cur_map_blocks > MAX_MAP_BLOCKS) ? MAX_MAP_BLOCKS : int'(cur_map_blocks);
    endfunction

    // first-fit allocate / free against the shadow bitmap
    function automatic t_result apply_request(input t_req r);
        t_result         res;
        int              nwords;
        logic [ID_W-1:0] rel;
        logic [ID_W-1:0] map_idx;
        bit              found;
        res.alloc_id = '0;
        res.status   = ST_OK;
        found        = 1'b0;
        nwords       = active_maps() * WORDS_PER_MAP;
        if (r.func == FN_ALLOC) begin
            for (int w = 0; w < nwords && !found; w++) begin
                if (slot_map[w] != '1) begin
                    for (int b = 0; b < WORD_BITS && !found; b++) begin
                        if (!slot_map[w][b]) begin
                            slot_map[w][b] = 1'b1;
                            res.alloc_id   = ID_W'(w * WORD_BITS + b) + cur_offset;
                            found          = 1'b1;
                        end
                    end
                end
            end
            if (!found) res.status = ST_FULL;
        end else begin
            // below the offset this wraps to a huge index
            rel     = r.free_id - cur_offset;
            map_idx = rel / SLOTS_PER_MAP;
            if (map_idx >= active_maps())
                res.status = ST_RANGE;
            else
                slot_map[rel / WORD_BITS][rel % WORD_BITS] = 1'b0;
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst_mode) return 0;
        r = $urandom_range(99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // drive one request word and wait for it to be taken
    task automatic send_req(input logic fn, input logic [ID_W-1:0] id);
        int      gap;
        t_req    r;
        t_result res;
        gap       = pick_gap();
        r.func    = fn;
        r.free_id = id;
        if (gap > 0) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_start <= 1'b1;
        i_req   <= r;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        res = apply_request(r);
        pending_results.push_back(res);
        if (fn == FN_ALLOC && res.status == ST_OK)
            live_slots.push_back(res.alloc_id - cur_offset);
    endtask

    // stop requesting and let every outstanding word come back
    task automatic drain();
        @(negedge i_clk);
        i_start <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pending_results.size() == 0 && !o_busy) break;
        end
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        if (idx == CFG_MAP_BLOCKS)
            cur_map_blocks = data[MAPCNT_W-1:0];
        else
            cur_map_blocks = cur_map_blocks;
        if (idx == CFG_DATA_OFFSET) cur_offset = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [MAPCNT_W-1:0] maps, input logic [ID_W-1:0] offs);
        drain();
        write_cfg(CFG_MAP_BLOCKS, CFG_DATA_W'(maps));
        write_cfg(CFG_DATA_OFFSET, offs);
    endtask

    // free a block that is currently handed out
    task automatic free_live();
        int          k;
        int unsigned slot;
        k    = $urandom_range(live_slots.size() - 1);
        slot = live_slots[k];
        live_slots.delete(k);
        send_req(FN_FREE, ID_W'(slot) + cur_offset);
    endtask

    // edges of the map, free of an unused slot, wrap below the offset, empty and oversize map
    task automatic test_directed();
        burst_mode = 1'b0;
        repeat (3) send_req(FN_ALLOC, '1);
        send_req(FN_FREE, 32'd1);
        send_req(FN_ALLOC, '0);
        send_req(FN_FREE, 32'd5);
        send_req(FN_FREE, 32'd32767);
        send_req(FN_FREE, 32'd32768);
        send_req(FN_FREE, '1);
        send_req(FN_FREE, '0);
        set_config(4'd8, 32'd100);
        send_req(FN_FREE, 32'd50);
        send_req(FN_ALLOC, 32'h5555_5555);
        set_config(4'd0, 32'd100);
        send_req(FN_ALLOC, 32'hAAAA_AAAA);
        send_req(FN_FREE, 32'd100);
        set_config(4'd15, 32'd100);
        send_req(FN_FREE, 32'd100 + 32'd32767);
        send_req(FN_FREE, 32'd100 + 32'd32768);
        set_config(4'd8, 32'hFFFF_FFFF);
        send_req(FN_ALLOC, '0);
        send_req(FN_ALLOC, '0);
        send_req(FN_FREE, 32'd2);
        send_req(FN_FREE, 32'hFFFF_FFFE);
    endtask

    // grow a one-block map across several words, then punch holes and refill
    task automatic test_fill();
        burst_mode = 1'b0;
        set_config(4'd1, $urandom);
        repeat (150) send_req(FN_ALLOC, $urandom);
        for (int n = 0; n < 20; n++) begin
            if ($urandom_range(1) == 0)
                send_req(FN_FREE, cur_offset + ID_W'($urandom_range(SLOTS_PER_MAP - 1)));
            else
                send_req(FN_ALLOC, $urandom);
        end
        // top word of the map
        for (int b = 0; b < WORD_BITS; b += 9)
            send_req(FN_FREE, cur_offset + ID_W'(SLOTS_PER_MAP - WORD_BITS + b));
        repeat (10) send_req(FN_ALLOC, $urandom);
        set_config(4'd2, cur_offset);
        repeat (5) send_req(FN_ALLOC, $urandom);
    endtask

    // mixed traffic across a series of map sizes and offsets
    task automatic test_random();
        logic [MAPCNT_W-1:0] maps;
        logic [ID_W-1:0]     offs;
        int                  sel;
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: maps = 4'd8;
                1: maps = 4'd1;
                2: maps = 4'd15;
                3: maps = 4'd0;
                default: maps = MAPCNT_W'($urandom_range(1, 15));
            endcase
            case ($urandom_range(3))
                0: offs = '0;
                1: offs = 32'hFFFF_FFFF - ID_W'($urandom_range(40000));
                default: offs = $urandom;
            endcase
            set_config(maps, offs);
            for (int n = 0; n < 85; n++) begin
                if (n % 40 == 0) burst_mode = ($urandom_range(3) == 0);
                sel = $urandom_range(99);
                if (sel < 48)
                    send_req(FN_ALLOC, $urandom);
                else if (sel < 85 && live_slots.size() > 0)
                    free_live();
                else begin
                    case ($urandom_range(2))
                        0: send_req(FN_FREE, $urandom);
                        1: send_req(FN_FREE, cur_offset + ID_W'($urandom_range(32768 + 64)));
                        default: send_req(FN_FREE, cur_offset - ID_W'($urandom_range(1, 8)));
                    endcase
                end
            end
        end
    endtask

    // result checker: oldest expectation against each done word
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual id %h status %0d",
                         $time, o_result.alloc_id, o_result.status);
                err_cnt++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_result.alloc_id !== exp_res.alloc_id) begin
                    $display("%0t: alloc_id mismatch: expected %h actual %h",
                             $time, exp_res.alloc_id, o_result.alloc_id);
                    err_cnt++;
                end
                if (o_result.status !== exp_res.status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, exp_res.status, o_result.status);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_req          = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        err_cnt        = 0;
        idle_cycles    = 0;
        burst_mode     = 1'b0;
        cur_map_blocks = MAPCNT_W'(8);
        cur_offset     = '0;
        for (int w = 0; w < TOTAL_WORDS; w++) slot_map[w] = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_fill();
        test_random();

        drain();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
